@@ design/spm_pkg.sv @@
`default_nettype none
package spm_pkg;

  // sizing
  localparam int MAX_TERMS = 8;
  localparam int EXP_BITS  = 10;
  localparam int IN_EXP_W  = 10;
  localparam int COEF_W    = 32;
  localparam int ACC_W     = 64;
  localparam int OUT_EXP_W = 11;
  localparam int TC_W      = 7;
  localparam int SUM_AW    = EXP_BITS + 1;
  localparam int SUM_DEPTH = 1 << SUM_AW;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int MAX_NZ    = MAX_TERMS * MAX_TERMS;
  localparam int NZ_W      = $clog2(MAX_NZ + 1);

  // operation codes
  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_ACC,
    ST_POST,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMPTY
  } spm_state_t;

  typedef struct packed {
    logic                     operation;
    logic [IN_EXP_W-1:0]      exponent;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last;
  } spm_in_t;

  typedef struct packed {
    logic [OUT_EXP_W-1:0]    product_exponent;
    logic signed [ACC_W-1:0] product_coefficient;
    logic [TC_W-1:0]         term_count;
    logic                    empty_res;
    logic                    final_term;
  } spm_out_t;

  typedef struct packed {
    logic store;
    logic loop_init;
    logic mul;
    logic acc;
    logic clr;
    logic scan_take;
    logic emit_empty;
    logic run_end;
  } spm_cmd_t;

  typedef struct packed {
    logic counts_zero;
    logic pair_last;
    logic nz_zero;
    logic hit;
    logic emit_last;
    logic out_free;
    logic clr_done;
  } spm_stat_t;

endpackage
`default_nettype wire

@@ design/spm_ram.sv @@
`default_nettype none
module spm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/spm_ctrl.sv @@
`default_nettype none
module spm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  input  wire spm_pkg::spm_stat_t stat,
  output logic                   in_stall,
  output spm_pkg::spm_cmd_t      cmd
);
  import spm_pkg::*;

  spm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.loop_init = 1'b1;
        state_nxt = stat.counts_zero ? ST_EMPTY : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.pair_last ? ST_POST : ST_MUL;
      end
      ST_POST: begin
        state_nxt = stat.nz_zero ? ST_EMPTY : ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!stat.hit) begin
          cmd.scan_take = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end else if (stat.out_free) begin
          cmd.scan_take = 1'b1;
          if (stat.emit_last) begin
            cmd.run_end = 1'b1;
            state_nxt   = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          cmd.run_end    = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/spm_dp.sv @@
`default_nettype none
module spm_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spm_pkg::spm_in_t  in_data,
  input  wire logic              out_stall,
  input  wire spm_pkg::spm_cmd_t cmd,
  output spm_pkg::spm_stat_t     stat,
  output logic                   out_valid,
  output spm_pkg::spm_out_t      out_data
);
  import spm_pkg::*;

  // term stores
  logic [EXP_BITS-1:0]      f_exp_r  [MAX_TERMS];
  logic signed [COEF_W-1:0] f_coef_r [MAX_TERMS];
  logic [EXP_BITS-1:0]      s_exp_r  [MAX_TERMS];
  logic signed [COEF_W-1:0] s_coef_r [MAX_TERMS];
  logic [CNT_W-1:0]         fcnt_r, scnt_r;

  // loop and scan counters
  logic [IDX_W-1:0]  i_r, j_r;
  logic [SUM_AW-1:0] scan_addr_r;
  logic [NZ_W-1:0]   nz_r, k_r;

  // product stage
  logic signed [ACC_W-1:0] prod_r;
  logic [SUM_AW-1:0]       paddr_r;

  // accumulator store ports
  logic              ram_we;
  logic [SUM_AW-1:0] ram_waddr, ram_raddr;
  logic [ACC_W-1:0]  ram_wdata, ram_rdata;

  logic [SUM_AW-1:0]       pe;
  logic signed [ACC_W-1:0] old_sum, new_sum, raw_sum;
  logic                    ovf, out_free, out_load;
  logic                    out_valid_r;
  spm_out_t                out_data_r;

  spm_ram #(
    .WIDTH(ACC_W),
    .DEPTH(SUM_DEPTH)
  ) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pe = SUM_AW'(f_exp_r[i_r]) + SUM_AW'(s_exp_r[j_r]);

  // saturating accumulate
  assign old_sum = $signed(ram_rdata);
  assign raw_sum = old_sum + prod_r;
  assign ovf     = (old_sum[ACC_W-1] == prod_r[ACC_W-1]) &&
                   (raw_sum[ACC_W-1] != old_sum[ACC_W-1]);
  always_comb begin
    if (ovf) begin
      new_sum = old_sum[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      new_sum = raw_sum;
    end
  end

  assign ram_we    = cmd.acc || cmd.clr || cmd.scan_take;
  assign ram_waddr = cmd.acc ? paddr_r : scan_addr_r;
  assign ram_wdata = cmd.acc ? new_sum : '0;
  assign ram_raddr = cmd.mul ? pe : scan_addr_r;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.scan_take && stat.hit) || cmd.emit_empty;

  always_comb begin
    stat.counts_zero = (fcnt_r == '0) || (scnt_r == '0);
    stat.pair_last   = ((CNT_W'(i_r) + CNT_W'(1)) == fcnt_r) &&
                       ((CNT_W'(j_r) + CNT_W'(1)) == scnt_r);
    stat.nz_zero     = (nz_r == '0);
    stat.hit         = (ram_rdata != '0);
    stat.emit_last   = ((k_r + NZ_W'(1)) == nz_r);
    stat.out_free    = out_free;
    stat.clr_done    = (scan_addr_r == '0);
  end

  function automatic spm_out_t out_data_nxt();
    spm_out_t o;
    o = '0;
    if (cmd.emit_empty) begin
      o.empty_res  = 1'b1;
      o.final_term = 1'b1;
    end else begin
      o.product_exponent    = OUT_EXP_W'(scan_addr_r);
      o.product_coefficient = $signed(ram_rdata);
      o.term_count          = TC_W'(nz_r);
      o.final_term          = stat.emit_last;
    end
    return o;
  endfunction

  // term loading, product and output registers, payload only
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (in_data.operation == OP_FIRST) begin
        if (fcnt_r < CNT_W'(MAX_TERMS)) begin
          f_exp_r[fcnt_r[IDX_W-1:0]]  <= in_data.exponent[EXP_BITS-1:0];
          f_coef_r[fcnt_r[IDX_W-1:0]] <= in_data.coefficient;
        end
      end else begin
        if (scnt_r < CNT_W'(MAX_TERMS)) begin
          s_exp_r[scnt_r[IDX_W-1:0]]  <= in_data.exponent[EXP_BITS-1:0];
          s_coef_r[scnt_r[IDX_W-1:0]] <= in_data.coefficient;
        end
      end
    end
    if (cmd.mul) begin
      prod_r  <= ACC_W'(f_coef_r[i_r] * s_coef_r[j_r]);
      paddr_r <= pe;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt();
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r      <= '0;
      scnt_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      scan_addr_r <= '1;
      nz_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (in_data.operation == OP_FIRST) begin
          if (fcnt_r < CNT_W'(MAX_TERMS)) begin
            fcnt_r <= fcnt_r + CNT_W'(1);
          end
        end else if (scnt_r < CNT_W'(MAX_TERMS)) begin
          scnt_r <= scnt_r + CNT_W'(1);
        end
      end
      if (cmd.loop_init) begin
        i_r         <= '0;
        j_r         <= '0;
        k_r         <= '0;
        scan_addr_r <= '1;
      end
      if (cmd.acc) begin
        if ((CNT_W'(j_r) + CNT_W'(1)) == scnt_r) begin
          j_r <= '0;
          i_r <= i_r + IDX_W'(1);
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
        if ((old_sum == '0) && (new_sum != '0)) begin
          nz_r <= nz_r + NZ_W'(1);
        end else if ((old_sum != '0) && (new_sum == '0)) begin
          nz_r <= nz_r - NZ_W'(1);
        end
      end
      if (cmd.clr || cmd.scan_take) begin
        scan_addr_r <= scan_addr_r - SUM_AW'(1);
      end
      if (cmd.scan_take && stat.hit && !cmd.run_end) begin
        k_r <= k_r + NZ_W'(1);
      end
      if (cmd.run_end) begin
        fcnt_r <= '0;
        scnt_r <= '0;
        nz_r   <= '0;
        k_r    <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_nz_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nz_r <= NZ_W'(MAX_NZ))
    else $error("nonzero count beyond pair count");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= nz_r)
    else $error("more terms emitted than nonzero sums");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a waiting result");

  a_fcnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store && !cmd.run_end && (in_data.operation == OP_FIRST) &&
    (fcnt_r < CNT_W'(MAX_TERMS)) |=> fcnt_r == $past(fcnt_r) + CNT_W'(1))
    else $error("first term count did not advance");

endmodule
`default_nettype wire

@@ design/sparse_polynomial_multiply.sv @@
// loads: one term beat per cycle, no result, in_stall low whenever idle
// run: after the beat with last, a multiply-accumulate pass (one read-modify-write of
//   the sum store per pair), then a scan of the sum-store addresses from 2047 down
//   to the lowest nonzero one
// empty product: one result with empty_res set, if a polynomial is empty or all sums are zero
// reset: synchronous active-low; a clearing pass writes zero through all 2048 sum
//   entries, with in_stall high, before the first term is taken
`default_nettype none
module sparse_polynomial_multiply (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire spm_pkg::spm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output spm_pkg::spm_out_t     out_data
);
  import spm_pkg::*;

  // command and status between controller and datapath
  spm_cmd_t  cmd;
  spm_stat_t stat;

  // controller: clear pass, load, pair loop, descending scan, empty result
  spm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_last (in_data.last),
    .stat    (stat),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  // datapath: term stores, multiplier, saturating accumulate, sum store,
  // nonzero count and the output register that parts the result side
  spm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
